// ===== rtl/core/tdhr_pkg.sv =====
// Shared types, character constants and the hex-character function for the
// decimal-to-hex text rewriter. No dependencies.
`default_nettype none

package tdhr_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_LOWER_A_OFFSET = 8'h57;  // 'a' - 10

  // Work flags of one queued item.
  typedef struct packed {
    logic has_hex;   // emit "0x" and hex digits
    logic has_byte;  // emit the carried byte last
    logic eot;       // final result closes the string
  } entry_flags_t;

  localparam int FLAGS_W = $bits(entry_flags_t);

  // Serializer phase for the item at the queue head.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_HEX,
    PH_CHAR
  } phase_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + wide;
    end
    return CH_LOWER_A_OFFSET + wide;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tdhr_queue.sv =====
// Short register queue between front and back of the text rewriter.
// Depends on nothing but its parameters.
`default_nettype none

module tdhr_queue #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/tdhr_front.sv =====
// Front of the text rewriter: accepts bytes, gathers digit runs into the
// accumulator and queues work for the back. Uses tdhr_pkg.
`default_nettype none

module tdhr_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             text_byte,
  input  wire logic                   end_of_text,
  input  wire logic                   q_full,
  output logic                        push,
  output logic [VALUE_WIDTH-1:0]      push_value,
  output logic [7:0]                  push_byte,
  output tdhr_pkg::entry_flags_t      push_flags
);

  import tdhr_pkg::*;

  logic [VALUE_WIDTH-1:0] acc;
  logic                   in_run;
  logic [VALUE_WIDTH-1:0] base;
  logic [VALUE_WIDTH-1:0] acc_dec;
  logic                   is_digit;
  logic                   accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

  // acc*10 + digit as two shifts and two adds, wrapping at VALUE_WIDTH
  assign base    = in_run ? acc : '0;
  assign acc_dec = (base << 3) + (base << 1)
                 + VALUE_WIDTH'(text_byte - CH_ZERO);

  always_comb begin
    push_value = acc;
    push_byte  = text_byte;
    push_flags = '{has_hex: in_run, has_byte: 1'b1, eot: end_of_text};
    if (is_digit) begin
      push_value = acc_dec;
      push_flags = '{has_hex: 1'b1, has_byte: 1'b0, eot: 1'b1};
    end
    // a digit without end mark only advances the run
    push = accept && !(is_digit && !end_of_text);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      in_run <= 1'b0;
    end else if (accept) begin
      if (is_digit && !end_of_text) begin
        acc    <= acc_dec;
        in_run <= 1'b1;
      end else begin
        acc    <= '0;
        in_run <= 1'b0;
      end
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (!in_run && acc == '0))
    else $error("state not cleared after end of text");
  a_digit_opens: assert property (@(posedge clk) disable iff (rst)
    (accept && is_digit && !end_of_text) |=> in_run)
    else $error("digit did not open a run");
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && !q_full))
    else $error("push without accepted item");

endmodule

`default_nettype wire

// ===== rtl/core/tdhr_back.sv =====
// Back of the text rewriter: serializes each queued item into what it
// flags of "0x", hex digits without leading zeros, byte. Uses tdhr_pkg.
`default_nettype none

module tdhr_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire logic [VALUE_WIDTH-1:0] q_value,
  input  wire logic [7:0]             q_byte,
  input  wire tdhr_pkg::entry_flags_t q_flags,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        last_of_run,
  output logic                        text_done
);

  import tdhr_pkg::*;

  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int IDX_W      = $clog2(HEX_DIGITS);
  localparam int PAD_W      = HEX_DIGITS * 4;

  phase_t           phase;
  phase_t           phase_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] msd;
  logic [PAD_W-1:0] padded;
  logic [3:0]       nib;
  logic             load;
  logic             step;
  logic [7:0]       ch;
  logic             last;

  assign padded = PAD_W'(q_value);
  assign nib    = padded[{idx, 2'b00} +: 4];
  assign load   = !out_valid || out_ready;
  assign step   = load && q_valid;

  // most significant nonzero digit; zero value leaves digit 0
  always_comb begin
    msd = '0;
    for (int i = 0; i < HEX_DIGITS; i++) begin
      if (padded[i*4 +: 4] != 4'd0) begin
        msd = IDX_W'(i);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    pop        = 1'b0;
    ch         = q_byte;
    last       = 1'b0;
    if (step) begin
      case (phase)
        PH_IDLE: begin
          if (q_flags.has_hex) begin
            ch         = CH_ZERO;
            idx_next   = msd;
            phase_next = PH_X;
          end else begin
            last = 1'b1;
            pop  = 1'b1;
          end
        end
        PH_X: begin
          ch         = CH_X;
          phase_next = PH_HEX;
        end
        PH_HEX: begin
          ch = hex_char(nib);
          if (idx == '0) begin
            if (q_flags.has_byte) begin
              phase_next = PH_CHAR;
            end else begin
              last       = 1'b1;
              pop        = 1'b1;
              phase_next = PH_IDLE;
            end
          end else begin
            idx_next = idx - 1'b1;
          end
        end
        PH_CHAR: begin
          last       = 1'b1;
          pop        = 1'b1;
          phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte    <= ch;
      last_of_run <= last;
      text_done   <= last && q_flags.eot;
    end
  end

  a_busy_has_head: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> q_valid)
    else $error("serializer busy with empty queue");
  a_hex_phase_flag: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_X || phase == PH_HEX) |-> q_flags.has_hex)
    else $error("hex phase on item without number");
  a_char_phase_flag: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CHAR) |-> q_flags.has_byte)
    else $error("byte phase on item without byte");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_done) |-> last_of_run)
    else $error("text_done without last_of_run");

endmodule

`default_nettype wire

// ===== rtl/core/text_decimal_to_hex_rewriter_core.sv =====
// Top level of the decimal-to-hex text rewriter: front, queue and back.
// Depends on tdhr_pkg, tdhr_front, tdhr_queue and tdhr_back.
//
// Text bytes enter one per cycle while the queue has room. Non-digits pass
// through; a run of decimal digits is gathered modulo 2^VALUE_WIDTH and
// written back as "0x" plus lowercase hex without leading zeros, then the
// byte that ended the run. Input side: one item per cycle while the queue
// has room; a digit that does not close a run is taken and gives nothing.
// Output side: one result per cycle while out_ready and queued work allow;
// a number gives "0x" and 1 to (VALUE_WIDTH+3)/4 digits, plus its ending byte.
// The QUEUE_DEPTH-entry queue lets input run ahead while the serializer
// works through a number; when it fills, in_ready drops until a slot frees.
`default_nettype none

module text_decimal_to_hex_rewriter_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            text_done
);

  import tdhr_pkg::*;

  localparam int ENTRY_W = VALUE_WIDTH + 8 + FLAGS_W;

  logic                   push;
  logic [VALUE_WIDTH-1:0] push_value;
  logic [7:0]             push_byte;
  entry_flags_t           push_flags;
  logic                   q_full;
  logic                   q_valid;
  logic                   pop;
  logic [ENTRY_W-1:0]     q_head;
  logic [VALUE_WIDTH-1:0] q_value;
  logic [7:0]             q_byte;
  entry_flags_t           q_flags;

  assign q_value = q_head[ENTRY_W-1 -: VALUE_WIDTH];
  assign q_byte  = q_head[FLAGS_W +: 8];
  assign q_flags = entry_flags_t'(q_head[FLAGS_W-1:0]);

  tdhr_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .q_full     (q_full),
    .push       (push),
    .push_value (push_value),
    .push_byte  (push_byte),
    .push_flags (push_flags)
  );

  tdhr_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_value, push_byte, push_flags}),
    .full      (q_full),
    .pop       (pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  tdhr_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_value    (q_value),
    .q_byte     (q_byte),
    .q_flags    (q_flags),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run),
    .text_done  (text_done)
  );

endmodule

`default_nettype wire
